### hdl/ssbfd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder package
// Widths, register indexes and the segment decode table shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssbfd_pkg;

  localparam int TIME_W      = 32;
  localparam int SPACING_W   = 10;
  localparam int GAP_W       = 16;
  localparam int REPEATS_W   = 8;
  localparam int FRAME_WIDTH = 24;
  localparam int BITS_W      = 5;
  localparam int SEG_W       = 7;
  localparam int CHAR_W      = 7;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int TABLE_LEN   = 22;

  localparam logic [BITS_W-1:0]    BITS_FRAME  = BITS_W'(FRAME_WIDTH);
  localparam logic [BITS_W-1:0]    BITS_SAT    = BITS_W'(FRAME_WIDTH + 1);
  localparam logic [REPEATS_W-1:0] REPEATS_MAX = '1;
  localparam logic [SEG_W-1:0]     CHECK_MASK  = 7'h4B;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_EDGE_SPACING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_REPEATS   = 2'd2;

  localparam logic [SPACING_W-1:0] RESET_MIN_EDGE_SPACING = 10'd10;
  localparam logic [GAP_W-1:0]     RESET_FRAME_GAP        = 16'd500;
  localparam logic [REPEATS_W-1:0] RESET_STABLE_REPEATS   = 8'd3;

  typedef logic [FRAME_WIDTH-1:0] frame_t;

  typedef struct packed {
    logic              hit;
    logic [CHAR_W-1:0] ch;
  } digit_t;

  localparam logic [SEG_W-1:0] SEG_CODES [TABLE_LEN] = '{
    7'h7E, 7'h30, 7'h34, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h73,
    7'h00, 7'h37, 7'h0E, 7'h4F, 7'h0D, 7'h0F, 7'h67, 7'h01, 7'h03, 7'h05, 7'h1D
  };

  localparam logic [CHAR_W-1:0] SEG_CHARS [TABLE_LEN] = '{
    7'h30, 7'h31, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h20, 7'h48, 7'h4C, 7'h45, 7'h63, 7'h74, 7'h50, 7'h2D, 7'h2D, 7'h72, 7'h6F
  };

  function automatic digit_t decode_digit(input logic [SEG_W-1:0] pattern);
    digit_t d;
    d.hit = 1'b0;
    d.ch  = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (!d.hit && SEG_CODES[i] == pattern) begin
        d.hit = 1'b1;
        d.ch  = SEG_CHARS[i];
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### hdl/ssbfd_if.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder channels
// Valid/ready channels for bus edges, decoded results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssbfd_edge_if;
  import ssbfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time_us;
  logic              bus_level;
  modport source (output valid, output edge_time_us, output bus_level, input ready);
  modport sink (input valid, input edge_time_us, input bus_level, output ready);
endinterface

interface ssbfd_result_if;
  import ssbfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_left;
  logic [CHAR_W-1:0] char_middle;
  logic [CHAR_W-1:0] char_right;
  logic [SEG_W-1:0]  seg_left;
  logic [SEG_W-1:0]  seg_middle;
  logic [SEG_W-1:0]  seg_right;
  logic              heat_flag;
  logic              pump_on;
  logic              light_flag;
  logic              text_changed;
  logic              raw_changed;
  logic              lamp_changed;
  modport source (
    output valid, output char_left, output char_middle, output char_right,
    output seg_left, output seg_middle, output seg_right, output heat_flag,
    output pump_on, output light_flag, output text_changed, output raw_changed,
    output lamp_changed, input ready
  );
  modport sink (
    input valid, input char_left, input char_middle, input char_right,
    input seg_left, input seg_middle, input seg_right, input heat_flag,
    input pump_on, input light_flag, input text_changed, input raw_changed,
    input lamp_changed, output ready
  );
endinterface

interface ssbfd_cfg_if;
  import ssbfd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/ssbfd_front.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder front end
// Filters noise edges, detects frame gaps and assembles 24-bit frames.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbfd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ssbfd_edge_if.sink                       bus_edge,
  input  wire logic [ssbfd_pkg::SPACING_W-1:0] min_spacing,
  input  wire logic [ssbfd_pkg::GAP_W-1:0]     frame_gap,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output ssbfd_pkg::frame_t                push_data
);
  import ssbfd_pkg::*;

  logic [TIME_W-1:0] prev_time;
  frame_t            shift_frame;
  logic [BITS_W-1:0] bits_seen;

  logic [TIME_W-1:0] elapsed;
  logic              noise;
  logic              gap;
  logic              take;
  frame_t            base_frame;
  logic [BITS_W-1:0] base_bits;
  frame_t            shift_frame_next;
  logic [BITS_W-1:0] bits_seen_next;

  assign bus_edge.ready = push_ready;

  always_comb begin
    elapsed          = bus_edge.edge_time_us - prev_time;
    noise            = elapsed < {{(TIME_W-SPACING_W){1'b0}}, min_spacing};
    gap              = (bits_seen != '0) && (elapsed > {{(TIME_W-GAP_W){1'b0}}, frame_gap});
    take             = bus_edge.valid && bus_edge.ready && !noise;
    base_frame       = gap ? '0 : shift_frame;
    base_bits        = gap ? '0 : bits_seen;
    shift_frame_next = {base_frame[FRAME_WIDTH-2:0], bus_edge.bus_level};
    bits_seen_next   = (base_bits < BITS_SAT) ? base_bits + 1'b1 : base_bits;
  end

  assign push_valid = take && (bits_seen_next == BITS_FRAME);
  assign push_data  = shift_frame_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time   <= '0;
      shift_frame <= '0;
      bits_seen   <= '0;
    end else if (take) begin
      prev_time   <= bus_edge.edge_time_us;
      shift_frame <= shift_frame_next;
      bits_seen   <= bits_seen_next;
    end
  end

  a_bits_saturate : assert property (@(posedge clk) disable iff (rst)
    bits_seen <= BITS_SAT)
    else $error("bit count passed its saturation value");

  a_push_needs_frame : assert property (@(posedge clk) disable iff (rst)
    push_valid |=> bits_seen == BITS_FRAME)
    else $error("frame pushed without a full bit count");

endmodule

`default_nettype wire

### hdl/ssbfd_queue.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder frame queue
// Two-entry queue of completed frames between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbfd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire ssbfd_pkg::frame_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output ssbfd_pkg::frame_t      pop_data
);
  import ssbfd_pkg::*;

  frame_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("frame offered to a full queue");

endmodule

`default_nettype wire

### hdl/ssbfd_back.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder back end
// Decodes frames, tracks stability and change, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbfd_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             pop_valid,
  output logic                                  pop_ready,
  input  wire ssbfd_pkg::frame_t                pop_data,
  input  wire logic [ssbfd_pkg::REPEATS_W-1:0]  stable_repeats,
  ssbfd_result_if.source                        result
);
  import ssbfd_pkg::*;

  logic [3*CHAR_W-1:0] cand_text;
  logic                cand_valid;
  logic [REPEATS_W-1:0] repeat_count;
  logic [3*CHAR_W-1:0] acc_text;
  logic [3*SEG_W-1:0]  acc_raw;
  logic [STATUS_W-1:0] acc_lamps;
  logic                acc_valid;
  logic                out_valid;

  logic [SEG_W-1:0]     seg0, seg1, seg2;
  logic [STATUS_W-1:0]  status;
  digit_t               d0, d1, d2;
  logic                 decoded;
  logic [3*CHAR_W-1:0]  text;
  logic [3*SEG_W-1:0]   raw;
  logic [STATUS_W-1:0]  lamps;
  logic                 same;
  logic [REPEATS_W-1:0] repeat_count_next;
  logic                 stable;
  logic                 tc, rc, lc;
  logic                 take;
  logic                 load;

  assign pop_ready = !out_valid || result.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    seg0    = pop_data[23:17];
    seg1    = pop_data[16:10];
    seg2    = pop_data[9:3];
    status  = pop_data[2:0];
    d0      = decode_digit(seg0);
    d1      = decode_digit(seg1);
    d2      = decode_digit(seg2);
    decoded = ((seg0 & CHECK_MASK) == '0) && !status[0] && d0.hit && d1.hit && d2.hit;
    text    = {d0.ch, d1.ch, d2.ch};
    raw     = {seg0, seg1, seg2};
    lamps   = {seg0[2], status[2], status[1]};
    same    = cand_valid && (text == cand_text);
    if (!same) begin
      repeat_count_next = REPEATS_W'(1);
    end else if (repeat_count != REPEATS_MAX) begin
      repeat_count_next = repeat_count + 1'b1;
    end else begin
      repeat_count_next = repeat_count;
    end
    stable = repeat_count_next >= stable_repeats;
    tc     = !acc_valid || (text != acc_text);
    rc     = !acc_valid || (raw != acc_raw);
    lc     = !acc_valid || (lamps != acc_lamps);
    load   = take && decoded && stable && (tc || rc || lc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_text    <= '0;
      cand_valid   <= 1'b0;
      repeat_count <= '0;
      acc_text     <= '0;
      acc_raw      <= '0;
      acc_lamps    <= '0;
      acc_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take && decoded) begin
        cand_text    <= text;
        cand_valid   <= 1'b1;
        repeat_count <= repeat_count_next;
        if (stable) begin
          acc_text  <= text;
          acc_raw   <= raw;
          acc_lamps <= lamps;
          acc_valid <= 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.char_left    <= d0.ch;
      result.char_middle  <= d1.ch;
      result.char_right   <= d2.ch;
      result.seg_left     <= seg0;
      result.seg_middle   <= seg1;
      result.seg_right    <= seg2;
      result.heat_flag    <= lamps[2];
      result.pump_on      <= lamps[1];
      result.light_flag   <= lamps[0];
      result.text_changed <= tc;
      result.raw_changed  <= rc;
      result.lamp_changed <= lc;
    end
  end

  assign result.valid = out_valid;

  a_result_has_change : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.text_changed || result.raw_changed || result.lamp_changed))
    else $error("result word without any change flag");

  a_result_after_accept : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> acc_valid && cand_valid)
    else $error("result word without an accepted frame");

endmodule

`default_nettype wire

### hdl/seven_segment_bus_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder
// Sniffs a clocked 24-bit display bus and reports changes of decoded frames.
// ----------------------------------------------------------------------------
// The bus_edge channel takes one word per display-bus clock edge: its
// microsecond timestamp and the sampled data bit. Up to one edge is taken
// per cycle. The front end filters noise edges, restarts frames after long
// gaps and pushes each completed 24-bit frame into a two-entry queue.
// The back end decodes one queued frame per cycle unless its output is held,
// applies the repeat and change checks and places a result word in an
// output register. Each result word passes through the queue and the output
// register on its way out. Most edges produce no result word.
// Registers are written over the cfg channel, which is always ready.
// Reset restores the register defaults and clears all frame, candidate and
// accepted state; the block takes edges as soon as reset ends.
// When the receiver stalls, the result word holds, the back end stops
// taking frames, and once the queue is full bus_edge drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_bus_frame_decoder_unit (
  input  wire logic      clk,
  input  wire logic      rst,
  ssbfd_edge_if.sink     bus_edge,
  ssbfd_result_if.source result,
  ssbfd_cfg_if.sink      cfg
);
  import ssbfd_pkg::*;

  logic [SPACING_W-1:0] min_spacing;
  logic [GAP_W-1:0]     frame_gap;
  logic [REPEATS_W-1:0] stable_repeats;

  logic   push_valid;
  logic   push_ready;
  frame_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  frame_t pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_spacing    <= RESET_MIN_EDGE_SPACING;
      frame_gap      <= RESET_FRAME_GAP;
      stable_repeats <= RESET_STABLE_REPEATS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MIN_EDGE_SPACING: min_spacing    <= cfg.data[SPACING_W-1:0];
        REG_FRAME_GAP:        frame_gap      <= cfg.data[GAP_W-1:0];
        REG_STABLE_REPEATS:   stable_repeats <= cfg.data[REPEATS_W-1:0];
        default: ;
      endcase
    end
  end

  ssbfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .bus_edge    (bus_edge),
    .min_spacing (min_spacing),
    .frame_gap   (frame_gap),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  ssbfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ssbfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .stable_repeats (stable_repeats),
    .result         (result)
  );

endmodule

`default_nettype wire

### dv/ssbfd_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder checker
// Watches the edge, register and result channels and tracks the decoder's
// behavior on its own: edge filtering, frame assembly, digit lookup, the
// repeat count and the change test. Every result word is compared field by
// field with the oldest predicted word, and failures are counted.
// ----------------------------------------------------------------------------

module ssbfd_frame_checker (
  input  logic    clk,
  input  logic    rst,
  ssbfd_edge_if   edge_mon,
  ssbfd_result_if result_mon,
  ssbfd_cfg_if    cfg_mon,
  output int      mismatches,
  output int      words_checked,
  output int      words_pending
);
  import ssbfd_pkg::*;

  localparam logic [4:0] FRAME_LEN     = 5'd24;
  localparam logic [4:0] COUNT_CAP     = 5'd25;
  localparam logic [7:0] RUN_CAP       = 8'd255;
  localparam logic [6:0] LEFT_MASK     = 7'h4B;
  localparam logic [9:0] SPACING_INIT  = 10'd10;
  localparam logic [15:0] GAP_INIT     = 16'd500;
  localparam logic [7:0] REPEATS_INIT  = 8'd3;

  typedef struct packed {
    logic [6:0] char_left;
    logic [6:0] char_middle;
    logic [6:0] char_right;
    logic [6:0] seg_left;
    logic [6:0] seg_middle;
    logic [6:0] seg_right;
    logic       heat_flag;
    logic       pump_on;
    logic       light_flag;
    logic       text_changed;
    logic       raw_changed;
    logic       lamp_changed;
  } display_word_t;

  logic [9:0]    spacing_us;
  logic [15:0]   gap_us;
  logic [7:0]    repeats_needed;
  logic [31:0]   prev_edge_us;
  logic [23:0]   frame_shift;
  logic [4:0]    bits_in_frame;
  logic [20:0]   cand_text;
  logic          cand_valid;
  logic [7:0]    cand_run;
  logic [20:0]   shown_text;
  logic [20:0]   shown_raw;
  logic [2:0]    shown_lamps;
  logic          shown_valid;
  display_word_t expected_words [$];

  // The top bit tells whether the pattern is a known glyph.
  function automatic logic [7:0] glyph_of(input logic [6:0] segs);
    case (segs)
      7'h7E: return {1'b1, 7'h30};
      7'h30: return {1'b1, 7'h31};
      7'h34: return {1'b1, 7'h31};
      7'h6D: return {1'b1, 7'h32};
      7'h79: return {1'b1, 7'h33};
      7'h33: return {1'b1, 7'h34};
      7'h5B: return {1'b1, 7'h35};
      7'h5F: return {1'b1, 7'h36};
      7'h70: return {1'b1, 7'h37};
      7'h7F: return {1'b1, 7'h38};
      7'h73: return {1'b1, 7'h39};
      7'h00: return {1'b1, 7'h20};
      7'h37: return {1'b1, 7'h48};
      7'h0E: return {1'b1, 7'h4C};
      7'h4F: return {1'b1, 7'h45};
      7'h0D: return {1'b1, 7'h63};
      7'h0F: return {1'b1, 7'h74};
      7'h67: return {1'b1, 7'h50};
      7'h01: return {1'b1, 7'h2D};
      7'h03: return {1'b1, 7'h2D};
      7'h05: return {1'b1, 7'h72};
      7'h1D: return {1'b1, 7'h6F};
      default: return 8'h00;
    endcase
  endfunction

  function automatic string word_image(input display_word_t w);
    return $sformatf("chars %h %h %h segs %h %h %h lamps %b%b%b changed %b%b%b",
                     w.char_left, w.char_middle, w.char_right, w.seg_left,
                     w.seg_middle, w.seg_right, w.heat_flag, w.pump_on, w.light_flag,
                     w.text_changed, w.raw_changed, w.lamp_changed);
  endfunction

  always @(posedge clk) begin : track_display_bus
    display_word_t got;
    display_word_t want;
    logic [31:0]   elapsed;
    logic [6:0]    seg_l, seg_m, seg_r;
    logic [7:0]    glyph_l, glyph_m, glyph_r;
    logic [2:0]    status, lamps;
    logic [20:0]   text, raw;
    logic          tc, rc, lc;
    if (rst) begin
      spacing_us     = SPACING_INIT;
      gap_us         = GAP_INIT;
      repeats_needed = REPEATS_INIT;
      prev_edge_us   = '0;
      frame_shift    = '0;
      bits_in_frame  = '0;
      cand_text      = '0;
      cand_valid     = 1'b0;
      cand_run       = '0;
      shown_text     = '0;
      shown_raw      = '0;
      shown_lamps    = '0;
      shown_valid    = 1'b0;
      mismatches     = 0;
      words_checked  = 0;
      expected_words.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        got = '{char_left: result_mon.char_left, char_middle: result_mon.char_middle,
                char_right: result_mon.char_right, seg_left: result_mon.seg_left,
                seg_middle: result_mon.seg_middle, seg_right: result_mon.seg_right,
                heat_flag: result_mon.heat_flag, pump_on: result_mon.pump_on,
                light_flag: result_mon.light_flag, text_changed: result_mon.text_changed,
                raw_changed: result_mon.raw_changed, lamp_changed: result_mon.lamp_changed};
        words_checked++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: result word with none predicted: %s", $time, word_image(got));
          end
        end else begin
          want = expected_words.pop_front();
          if (got.char_left !== want.char_left || got.char_middle !== want.char_middle ||
              got.char_right !== want.char_right || got.seg_left !== want.seg_left ||
              got.seg_middle !== want.seg_middle || got.seg_right !== want.seg_right ||
              got.heat_flag !== want.heat_flag || got.pump_on !== want.pump_on ||
              got.light_flag !== want.light_flag || got.text_changed !== want.text_changed ||
              got.raw_changed !== want.raw_changed ||
              got.lamp_changed !== want.lamp_changed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: result word differs\n  expected %s\n  actual   %s", $time,
                       word_image(want), word_image(got));
            end
          end
        end
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MIN_EDGE_SPACING: spacing_us = cfg_mon.data[SPACING_W-1:0];
          REG_FRAME_GAP: gap_us = cfg_mon.data[GAP_W-1:0];
          REG_STABLE_REPEATS: repeats_needed = cfg_mon.data[REPEATS_W-1:0];
          default: ;
        endcase
      end

      if (edge_mon.valid && edge_mon.ready) begin
        elapsed = edge_mon.edge_time_us - prev_edge_us;
        if (elapsed >= spacing_us) begin
          if (bits_in_frame != 0 && elapsed > gap_us) begin
            frame_shift   = '0;
            bits_in_frame = '0;
          end
          prev_edge_us = edge_mon.edge_time_us;
          frame_shift  = {frame_shift[22:0], edge_mon.bus_level};
          if (bits_in_frame < COUNT_CAP) bits_in_frame++;
          if (bits_in_frame == FRAME_LEN) begin
            seg_l   = frame_shift[23:17];
            seg_m   = frame_shift[16:10];
            seg_r   = frame_shift[9:3];
            status  = frame_shift[2:0];
            glyph_l = glyph_of(seg_l);
            glyph_m = glyph_of(seg_m);
            glyph_r = glyph_of(seg_r);
            // A frame that fails the mask or holds an unknown digit leaves
            // the stability state as it was.
            if ((seg_l & LEFT_MASK) == '0 && !status[0] && glyph_l[7] && glyph_m[7] &&
                glyph_r[7]) begin
              text  = {glyph_l[6:0], glyph_m[6:0], glyph_r[6:0]};
              raw   = {seg_l, seg_m, seg_r};
              lamps = {seg_l[2], status[2], status[1]};
              if (cand_valid && text == cand_text) begin
                if (cand_run != RUN_CAP) cand_run++;
              end else begin
                cand_text  = text;
                cand_valid = 1'b1;
                cand_run   = 8'd1;
              end
              if (cand_run >= repeats_needed) begin
                tc          = !shown_valid || text != shown_text;
                rc          = !shown_valid || raw != shown_raw;
                lc          = !shown_valid || lamps != shown_lamps;
                shown_text  = text;
                shown_raw   = raw;
                shown_lamps = lamps;
                shown_valid = 1'b1;
                if (tc || rc || lc) begin
                  want.char_left    = glyph_l[6:0];
                  want.char_middle  = glyph_m[6:0];
                  want.char_right   = glyph_r[6:0];
                  want.seg_left     = seg_l;
                  want.seg_middle   = seg_m;
                  want.seg_right    = seg_r;
                  want.heat_flag    = lamps[2];
                  want.pump_on      = lamps[1];
                  want.light_flag   = lamps[0];
                  want.text_changed = tc;
                  want.raw_changed  = rc;
                  want.lamp_changed = lc;
                  expected_words.push_back(want);
                end
              end
            end
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

### dv/seven_segment_bus_frame_decoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment bus frame decoder testbench
// Plays display-bus edges into the decoder: repeated well-formed frames with
// random digits and lamp bits, mixed with noise edges, cut-short and overlong
// frames, frames that fail the mask and frames with unknown digits. Register
// settings change between phases, both sides idle at random, and the result
// side holds off once for a long stretch. A checker module does the
// comparison; this module drives the block and gives the verdict.
// ----------------------------------------------------------------------------

module seven_segment_bus_frame_decoder_unit_test;
  import ssbfd_pkg::*;

  localparam int LIMIT_NS           = 3_000_000;
  localparam int FRAME_LEN          = 24;
  localparam int SETTLE_CYCLES      = 8;
  localparam int RESULT_HOLD_CYCLES = 800;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [6:0]  UNKNOWN_SEGS   = 7'h7D;
  localparam logic [23:0] DIRECTED_FRAME = {7'h34, 7'h37, 7'h4F, 3'b110};
  localparam logic [6:0]  LEFT_SEGS [3]  = '{7'h00, 7'h30, 7'h34};
  localparam logic [6:0]  GLYPH_SEGS [22] = '{
    7'h7E, 7'h30, 7'h34, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h73,
    7'h00, 7'h37, 7'h0E, 7'h4F, 7'h0D, 7'h0F, 7'h67, 7'h01, 7'h03, 7'h05, 7'h1D
  };

  logic        clk;
  logic        rst;
  logic [31:0] kept_us;
  logic [31:0] spacing_set;
  logic [31:0] gap_set;
  logic [31:0] repeats_set;
  int          kept_edges;
  int          edges_sent;
  int          settings_count;
  int          sender_idle_pct;
  int          receiver_idle_pct;
  logic        stall_request;
  int          mismatches;
  int          words_checked;
  int          words_pending;

  ssbfd_edge_if   bus_edge_ch ();
  ssbfd_result_if result_ch ();
  ssbfd_cfg_if    cfg_ch ();

  seven_segment_bus_frame_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .bus_edge (bus_edge_ch),
    .result   (result_ch),
    .cfg      (cfg_ch)
  );

  ssbfd_frame_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .edge_mon      (bus_edge_ch),
    .result_mon    (result_ch),
    .cfg_mon       (cfg_ch),
    .mismatches    (mismatches),
    .words_checked (words_checked),
    .words_pending (words_pending)
  );

  initial clk = 1'b0;

  always #4 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("Run timed out with %0d words still predicted.", words_pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit held_off;
    held_off        = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !held_off) begin
        held_off = 1'b1;
        repeat (RESULT_HOLD_CYCLES) begin
          result_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic send_edge(input logic [31:0] stamp, input logic level);
    if (kept_edges < 640) begin
      sender_idle_pct   = 30;
      receiver_idle_pct = 49;
    end else if (kept_edges < 1280) begin
      sender_idle_pct   = 49;
      receiver_idle_pct = 30;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      bus_edge_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bus_edge_ch.valid        <= 1'b1;
    bus_edge_ch.edge_time_us <= stamp;
    bus_edge_ch.bus_level    <= level;
    do @(posedge clk); while (!bus_edge_ch.ready);
    @(negedge clk);
    edges_sent++;
  endtask

  function automatic logic [31:0] gap_step();
    logic [31:0] d;
    if ($urandom_range(9) == 0) d = $urandom();
    else d = gap_set + 32'd1 + $urandom_range(300);
    if (d <= gap_set || d < spacing_set) d = gap_set + spacing_set + 32'd1;
    return d;
  endfunction

  function automatic logic [31:0] bit_step();
    logic [31:0] span;
    span = gap_set - spacing_set;
    case ($urandom_range(9))
      0: return spacing_set;
      1: return gap_set;
      default: return spacing_set + $urandom_range(span > 80 ? 80 : span);
    endcase
  endfunction

  function automatic logic [6:0] twin_glyph(input logic [6:0] segs);
    case (segs)
      7'h30: return 7'h34;
      7'h34: return 7'h30;
      7'h01: return 7'h03;
      7'h03: return 7'h01;
      default: return segs;
    endcase
  endfunction

  // The first bit of every frame follows a gap; noise edges fall in between.
  task automatic send_frame(input logic [23:0] frame, input int nbits);
    logic level;
    for (int i = 0; i < nbits; i++) begin
      if (spacing_set != 0 && $urandom_range(99) < 5) begin
        send_edge(kept_us + $urandom_range(spacing_set - 1), 1'($urandom_range(1)));
      end
      level = (i < FRAME_LEN) ? frame[FRAME_LEN-1-i] : 1'($urandom_range(1));
      kept_us += (i == 0) ? gap_step() : bit_step();
      send_edge(kept_us, level);
      kept_edges++;
    end
  endtask

  task automatic run_phase(input int quota);
    int          start_count;
    int          kind;
    int          runs;
    logic [23:0] frame;
    start_count = kept_edges;
    while (kept_edges - start_count < quota) begin
      frame = {LEFT_SEGS[$urandom_range(2)], GLYPH_SEGS[$urandom_range(21)],
               GLYPH_SEGS[$urandom_range(21)], 2'($urandom_range(3)), 1'b0};
      kind  = $urandom_range(99);
      if (kind < 70) begin
        if (repeats_set > 4) runs = $urandom_range(4, 1);
        else runs = int'(repeats_set) - 1 + $urandom_range(2);
        if (runs < 1) runs = 1;
        for (int r = 0; r < runs; r++) begin
          if (r > 0 && $urandom_range(7) == 0) begin
            send_frame({frame[23:10], UNKNOWN_SEGS, frame[2:0]}, FRAME_LEN);
          end
          if (r > 0 && $urandom_range(4) == 0) begin
            frame[23:17] = twin_glyph(frame[23:17]);
            frame[16:10] = twin_glyph(frame[16:10]);
            frame[9:3]   = twin_glyph(frame[9:3]);
            frame[2:1]   = 2'($urandom_range(3));
          end
          send_frame(frame, FRAME_LEN);
        end
      end else if (kind < 78) begin
        send_frame(frame, $urandom_range(FRAME_LEN - 1, 1));
      end else if (kind < 85) begin
        send_frame(frame, FRAME_LEN + $urandom_range(6, 1));
      end else if (kind < 92) begin
        case ($urandom_range(2))
          0: frame[0] = 1'b1;
          1: frame[23:17] = 7'($urandom()) | 7'h01;
          default: frame[16:10] = 7'($urandom());
        endcase
        send_frame(frame, FRAME_LEN);
      end else begin
        send_frame(24'($urandom()), FRAME_LEN);
      end
    end
  endtask

  task automatic settle();
    bus_edge_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Unused upper data bits are set now and then; the block must ignore them.
  task automatic apply_settings(input logic [31:0] spacing, input logic [31:0] gap,
                                input logic [31:0] repeats, input bit touch_spare);
    settle();
    write_reg(REG_MIN_EDGE_SPACING,
              {(($urandom_range(1) != 0) ? 6'($urandom()) : 6'd0), spacing[9:0]});
    write_reg(REG_FRAME_GAP, gap[15:0]);
    write_reg(REG_STABLE_REPEATS,
              {(($urandom_range(1) != 0) ? 8'($urandom()) : 8'd0), repeats[7:0]});
    if (touch_spare) write_reg(REG_SPARE, 16'($urandom()));
    cfg_ch.valid <= 1'b0;
    spacing_set = {22'd0, spacing[9:0]};
    gap_set     = {16'd0, gap[15:0]};
    repeats_set = {24'd0, repeats[7:0]};
    settings_count++;
  endtask

  initial begin
    logic [31:0] s;
    rst                      = 1'b1;
    bus_edge_ch.valid        = 1'b0;
    bus_edge_ch.edge_time_us = '0;
    bus_edge_ch.bus_level    = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = REG_MIN_EDGE_SPACING;
    cfg_ch.data              = '0;
    stall_request            = 1'b0;
    sender_idle_pct          = 0;
    receiver_idle_pct        = 0;
    spacing_set              = 32'd10;
    gap_set                  = 32'd500;
    repeats_set              = 32'd3;
    kept_us                  = '0;
    kept_edges               = 0;
    edges_sent               = 0;
    settings_count           = 1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // The first edge comes too soon after time zero and is dropped as noise.
    // The frame that follows starts at the top of the time range and wraps.
    send_edge(32'd0, 1'b1);
    kept_us = 32'hFFFF_FFEB;
    for (int i = 0; i < FRAME_LEN; i++) begin
      kept_us += 32'd20;
      send_edge(kept_us, DIRECTED_FRAME[FRAME_LEN-1-i]);
      kept_edges++;
    end

    run_phase(180);
    apply_settings(0, 65535, 1, 1'b0);
    run_phase(200);
    apply_settings(1023, 65535, 2, 1'b0);
    run_phase(130);
    apply_settings(0, 0, 1, 1'b1);
    run_phase(130);
    apply_settings(5, 40, 0, 1'b0);
    run_phase(160);
    apply_settings(3, 200, 255, 1'b0);
    run_phase(80);
    apply_settings(2, 100, 1, 1'b0);
    stall_request = 1'b1;
    run_phase(260);
    repeat (3) begin
      s = $urandom_range(60);
      apply_settings(s, s + $urandom_range(3000), $urandom_range(4, 1), 1'b0);
      run_phase(140);
    end
    settle();

    $display("Drove %0d bus edges (%0d taken as bits) under %0d register settings,",
             edges_sent, kept_edges, settings_count);
    $display("with one %0d-cycle result hold-off; %0d decoded words compared.",
             RESULT_HOLD_CYCLES, words_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
